// ===== rtl/prefetch_slot_lru_manager_assert.svh =====
// assertion macros for the prefetch slot manager
`ifndef PREFETCH_SLOT_LRU_MANAGER_ASSERT_SVH
`define PREFETCH_SLOT_LRU_MANAGER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PSLM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSLM_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSLM_ASSERT(label, clk, rst, prop, msg)
`define PSLM_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/pslm_pkg.sv =====
// shared types and constants of the prefetch slot manager
package pslm_pkg;
   localparam int MaxSlots   = 16;
   localparam int SlotBits   = 4;
   localparam int QueueDepth = 16;
   localparam int QueueBits  = 4;
   localparam int LayerBits  = 16;

   typedef enum logic [1:0] {
      MODE_PREDICT  = 2'd0,
      MODE_GET      = 2'd1,
      MODE_DISPATCH = 2'd2,
      MODE_COMPLETE = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_QUEUED    = 4'd0,
      ST_CACHED    = 4'd1,
      ST_HIT       = 4'd2,
      ST_INFLIGHT  = 4'd3,
      ST_ISSUED    = 4'd4,
      ST_NOSLOT    = 4'd5,
      ST_DROPPED   = 4'd6,
      ST_REQUEUED  = 4'd7,
      ST_EMPTY     = 4'd8,
      ST_FETCH_OK  = 4'd9,
      ST_FETCH_BAD = 4'd10,
      ST_FULL      = 4'd11
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_POP  = 2'd1,
      FSM_EXEC = 2'd2,
      FSM_OUT  = 2'd3
   } fsm_type;

   typedef struct packed {
      logic capture;  // latch input item
      logic pop;      // launch queue read
      logic exec;     // evaluate and update state
   } cmd_type;

   typedef struct packed {
      logic is_dispatch;
      logic queue_empty;
   } stat_type;
endpackage

// ===== rtl/pslm_if.sv =====
// valid/ready channel interfaces
interface pslm_req_if;
   import pslm_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] mode;
   logic [LayerBits-1:0] layer;
   logic [SlotBits-1:0] slot;
   logic fetch_ok;
   modport source (output valid, mode, layer, slot, fetch_ok, input ready);
   modport sink (input valid, mode, layer, slot, fetch_ok, output ready);
endinterface

interface pslm_rsp_if;
   import pslm_pkg::*;
   logic valid;
   logic ready;
   logic [3:0] status;
   logic [SlotBits-1:0] slot_index;
   logic fetch_request;
   logic [LayerBits-1:0] fetch_layer;
   logic [31:0] hit_count;
   logic [31:0] miss_count;
   logic [31:0] eviction_count;
   logic [31:0] prefetch_count;
   logic [31:0] prediction_count;
   modport source (output valid, status, slot_index, fetch_request, fetch_layer,
      hit_count, miss_count, eviction_count, prefetch_count, prediction_count,
      input ready);
   modport sink (input valid, status, slot_index, fetch_request, fetch_layer,
      hit_count, miss_count, eviction_count, prefetch_count, prediction_count,
      output ready);
endinterface

// ===== rtl/pslm_ram.sv =====
// generic single-port-write ram with registered read
module pslm_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/pslm_ctrl.sv =====
// controller state machine
`include "prefetch_slot_lru_manager_assert.svh"
module pslm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pslm_pkg::stat_type stat,
   output pslm_pkg::cmd_type  cmd
);
   import pslm_pkg::*;

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = FSM_POP;
            end
         end
         FSM_POP: begin
            cmd.pop  = stat.is_dispatch && !stat.queue_empty;
            state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            cmd.exec = 1'b1;
            state_in = FSM_OUT;
         end
         FSM_OUT: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = FSM_POP;
               end else begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   `PSLM_ASSERT(a_exec_after_pop, clock, reset,
      (state_ff == FSM_POP) |=> (state_ff == FSM_EXEC), "exec must follow pop")
   `PSLM_ASSERT(a_out_after_exec, clock, reset,
      cmd.exec |=> rsp_valid, "result must follow exec")
   `PSLM_ASSERT(a_no_accept_busy, clock, reset,
      (state_ff == FSM_POP || state_ff == FSM_EXEC) |-> !req_ready,
      "no accept while working")
endmodule

// ===== rtl/pslm_dp.sv =====
// tag store, queue and counters datapath
`include "prefetch_slot_lru_manager_assert.svh"
module pslm_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  pslm_pkg::cmd_type            cmd,
   output pslm_pkg::stat_type           stat,
   input  logic                         csr_write,
   input  logic [4:0]                   csr_data,
   input  logic [1:0]                   in_mode,
   input  logic [pslm_pkg::LayerBits-1:0] in_layer,
   input  logic [pslm_pkg::SlotBits-1:0]  in_slot,
   input  logic                         in_fetch_ok,
   output logic [3:0]                   out_status,
   output logic [pslm_pkg::SlotBits-1:0]  out_slot_index,
   output logic                         out_fetch_request,
   output logic [pslm_pkg::LayerBits-1:0] out_fetch_layer,
   output logic [31:0]                  out_hit,
   output logic [31:0]                  out_miss,
   output logic [31:0]                  out_evict,
   output logic [31:0]                  out_pref,
   output logic [31:0]                  out_pred
);
   import pslm_pkg::*;

   logic [4:0] slots_ff;
   logic [1:0] mode_ff;
   logic [LayerBits-1:0] layer_ff;
   logic [SlotBits-1:0] slot_ff;
   logic ok_ff;
   logic [MaxSlots-1:0] valid_ff, busy_ff, demand_ff;
   logic [LayerBits-1:0] tag_ff [MaxSlots];
   logic [63:0] age_ff [MaxSlots];
   logic [QueueBits-1:0] head_ff;
   logic [QueueBits:0] count_ff;
   logic [63:0] stamp_ff;
   logic [31:0] hit_ff, miss_ff, evict_ff, pref_ff, pred_ff;
   logic [3:0] status_ff;
   logic [SlotBits-1:0] sidx_ff;
   logic freq_ff;
   logic [LayerBits-1:0] flayer_ff;

   // active slot count, saturating
   logic [4:0] nact;
   always_comb begin
      if (slots_ff == 5'd0) begin
         nact = 5'd1;
      end else if (slots_ff > 5'(MaxSlots)) begin
         nact = 5'(MaxSlots);
      end else begin
         nact = slots_ff;
      end
   end

   // queue memory
   logic q_we;
   logic [QueueBits-1:0] q_waddr;
   logic [LayerBits-1:0] q_wdata, q_rdata;
   pslm_ram #(.Width(LayerBits), .Depth(QueueDepth)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(head_ff), .rd_data(q_rdata)
   );

   assign stat.is_dispatch = (mode_ff == MODE_DISPATCH);
   assign stat.queue_empty = (count_ff == '0);

   // the layer looked up this step
   logic [LayerBits-1:0] key;
   assign key = (mode_ff == MODE_DISPATCH) ? q_rdata : layer_ff;

   logic [MaxSlots-1:0] act, rdy_m, bsy_m;
   logic rdy_hit, bsy_hit, vic_ok;
   logic [SlotBits-1:0] rdy_idx, bsy_idx, vic_idx;
   always_comb begin
      rdy_hit = 1'b0; bsy_hit = 1'b0;
      rdy_idx = '0; bsy_idx = '0;
      for (int i = 0; i < MaxSlots; i++) begin
         act[i]   = (5'(i) < nact);
         rdy_m[i] = act[i] && valid_ff[i] && !busy_ff[i] && tag_ff[i] == key;
         bsy_m[i] = act[i] && valid_ff[i] && busy_ff[i] && tag_ff[i] == key;
      end
      for (int i = MaxSlots - 1; i >= 0; i--) begin
         if (rdy_m[i]) begin
            rdy_hit = 1'b1; rdy_idx = SlotBits'(i);
         end
         if (bsy_m[i]) begin
            bsy_hit = 1'b1; bsy_idx = SlotBits'(i);
         end
      end
   end

   // least-age victim search as a pairwise tree, lower index wins ties;
   // slot state is steady between items, so the result is registered in
   // the queue-read cycle and used in the evaluate cycle
   logic                vo [SlotBits+1][MaxSlots];
   logic [63:0]         va [SlotBits+1][MaxSlots];
   logic [SlotBits-1:0] vi [SlotBits+1][MaxSlots];
   always_comb begin
      logic take_right;
      take_right = 1'b0;
      for (int k = 0; k <= SlotBits; k++) begin
         for (int j = 0; j < MaxSlots; j++) begin
            vo[k][j] = 1'b0; va[k][j] = '0; vi[k][j] = '0;
         end
      end
      for (int i = 0; i < MaxSlots; i++) begin
         vo[0][i] = act[i] && !busy_ff[i];
         va[0][i] = age_ff[i];
         vi[0][i] = SlotBits'(i);
      end
      for (int k = 1; k <= SlotBits; k++) begin
         for (int j = 0; j < (MaxSlots >> k); j++) begin
            take_right = vo[k-1][2*j+1] &&
                         (!vo[k-1][2*j] || va[k-1][2*j+1] < va[k-1][2*j]);
            if (take_right) begin
               vo[k][j] = 1'b1; va[k][j] = va[k-1][2*j+1]; vi[k][j] = vi[k-1][2*j+1];
            end else begin
               vo[k][j] = vo[k-1][2*j]; va[k][j] = va[k-1][2*j]; vi[k][j] = vi[k-1][2*j];
            end
         end
      end
   end

   logic vic_ok_ff, vic_ok_in;
   logic [SlotBits-1:0] vic_idx_ff, vic_idx_in;
   assign vic_ok_in  = vo[SlotBits][0];
   assign vic_idx_in = vi[SlotBits][0];
   always_ff @(posedge clock) begin
      vic_ok_ff  <= vic_ok_in;
      vic_idx_ff <= vic_idx_in;
   end
   assign vic_ok  = vic_ok_ff;
   assign vic_idx = vic_idx_ff;

   logic [QueueBits-1:0] tail;
   assign tail = head_ff + count_ff[QueueBits-1:0];

   always_comb begin
      q_we = 1'b0; q_waddr = tail; q_wdata = layer_ff;
      if (cmd.exec) begin
         if (mode_ff == MODE_PREDICT && !rdy_hit && count_ff < (QueueBits+1)'(QueueDepth)) begin
            q_we = 1'b1;
         end else if (mode_ff == MODE_DISPATCH && !stat.queue_empty && !rdy_hit &&
                      !bsy_hit && !vic_ok) begin
            q_we = 1'b1; q_wdata = q_rdata;
            q_waddr = head_ff + count_ff[QueueBits-1:0]; // tail before pop
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff  <= 5'(MaxSlots);
         valid_ff  <= '0; busy_ff <= '0; demand_ff <= '0;
         head_ff   <= '0; count_ff <= '0; stamp_ff <= 64'd1;
         hit_ff <= '0; miss_ff <= '0; evict_ff <= '0; pref_ff <= '0; pred_ff <= '0;
         for (int i = 0; i < MaxSlots; i++) begin
            tag_ff[i] <= '0; age_ff[i] <= '0;
         end
      end else begin
         if (csr_write) slots_ff <= csr_data;
         if (cmd.capture) begin
            mode_ff <= in_mode; layer_ff <= in_layer; slot_ff <= in_slot;
            ok_ff <= in_fetch_ok;
         end
         if (cmd.exec) begin
            status_ff <= ST_QUEUED; sidx_ff <= '0; freq_ff <= 1'b0; flayer_ff <= '0;
            case (mode_ff)
               MODE_PREDICT: begin
                  pred_ff <= pred_ff + 32'd1;
                  if (rdy_hit) status_ff <= ST_CACHED;
                  else if (count_ff >= (QueueBits+1)'(QueueDepth)) status_ff <= ST_FULL;
                  else count_ff <= count_ff + 1'b1;
               end
               MODE_GET: begin
                  if (rdy_hit) begin
                     age_ff[rdy_idx] <= stamp_ff; stamp_ff <= stamp_ff + 64'd1;
                     hit_ff <= hit_ff + 32'd1; status_ff <= ST_HIT; sidx_ff <= rdy_idx;
                  end else if (bsy_hit) begin
                     status_ff <= ST_INFLIGHT; sidx_ff <= bsy_idx;
                  end else if (!vic_ok) begin
                     status_ff <= ST_NOSLOT;
                  end else begin
                     if (valid_ff[vic_idx]) evict_ff <= evict_ff + 32'd1;
                     valid_ff[vic_idx] <= 1'b1; busy_ff[vic_idx] <= 1'b1;
                     demand_ff[vic_idx] <= 1'b1; tag_ff[vic_idx] <= layer_ff;
                     miss_ff <= miss_ff + 32'd1; status_ff <= ST_ISSUED;
                     sidx_ff <= vic_idx; freq_ff <= 1'b1; flayer_ff <= layer_ff;
                  end
               end
               MODE_DISPATCH: begin
                  if (stat.queue_empty) begin
                     status_ff <= ST_EMPTY;
                  end else begin
                     head_ff <= head_ff + 1'b1;
                     if (rdy_hit || bsy_hit) begin
                        status_ff <= ST_DROPPED; count_ff <= count_ff - 1'b1;
                     end else if (!vic_ok) begin
                        status_ff <= ST_REQUEUED;
                     end else begin
                        count_ff <= count_ff - 1'b1;
                        if (valid_ff[vic_idx]) evict_ff <= evict_ff + 32'd1;
                        valid_ff[vic_idx] <= 1'b1; busy_ff[vic_idx] <= 1'b1;
                        demand_ff[vic_idx] <= 1'b0; tag_ff[vic_idx] <= q_rdata;
                        status_ff <= ST_ISSUED; sidx_ff <= vic_idx;
                        freq_ff <= 1'b1; flayer_ff <= q_rdata;
                     end
                  end
               end
               MODE_COMPLETE: begin
                  if (!act[slot_ff] || !busy_ff[slot_ff]) begin
                     status_ff <= ST_DROPPED;
                  end else begin
                     busy_ff[slot_ff] <= 1'b0; demand_ff[slot_ff] <= 1'b0;
                     sidx_ff <= slot_ff;
                     if (ok_ff) begin
                        age_ff[slot_ff] <= stamp_ff; stamp_ff <= stamp_ff + 64'd1;
                        if (!demand_ff[slot_ff]) pref_ff <= pref_ff + 32'd1;
                        status_ff <= ST_FETCH_OK;
                     end else begin
                        valid_ff[slot_ff] <= 1'b0; status_ff <= ST_FETCH_BAD;
                     end
                  end
               end
               default: status_ff <= ST_DROPPED;
            endcase
         end
      end
   end

   assign out_status = status_ff; assign out_slot_index = sidx_ff;
   assign out_fetch_request = freq_ff; assign out_fetch_layer = flayer_ff;
   assign out_hit = hit_ff; assign out_miss = miss_ff; assign out_evict = evict_ff;
   assign out_pref = pref_ff; assign out_pred = pred_ff;

   `PSLM_ASSERT(a_count_bound, clock, reset,
      count_ff <= (QueueBits+1)'(QueueDepth), "queue count overflow")
   `PSLM_ASSERT(a_busy_valid, clock, reset,
      (busy_ff & ~valid_ff) == '0, "busy slot without tag")
   `PSLM_ASSERT(a_demand_busy, clock, reset,
      (demand_ff & ~busy_ff) == '0, "demand flag without fetch")
endmodule

// ===== rtl/prefetch_slot_lru_manager.sv =====
// top level of the prefetch slot manager
// an accepted item passes through a registered queue read, with the registered
//   least-age search beside it, then a tag compare and update step; its result
//   is held until taken, and a new item is accepted only as that result is taken
// reset: synchronous, clears tags, queue pointers, counters; stamp restarts at one
module prefetch_slot_lru_manager (
   input  logic       clock,
   input  logic       reset,
   pslm_req_if.sink   req,
   pslm_rsp_if.source rsp,
   input  logic       csr_write,
   input  logic [4:0] csr_data
);
   import pslm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   pslm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .cmd(cmd)
   );

   // tag store, pending queue and statistics
   pslm_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_write(csr_write), .csr_data(csr_data),
      .in_mode(req.mode), .in_layer(req.layer), .in_slot(req.slot),
      .in_fetch_ok(req.fetch_ok),
      .out_status(rsp.status), .out_slot_index(rsp.slot_index),
      .out_fetch_request(rsp.fetch_request), .out_fetch_layer(rsp.fetch_layer),
      .out_hit(rsp.hit_count), .out_miss(rsp.miss_count),
      .out_evict(rsp.eviction_count), .out_pref(rsp.prefetch_count),
      .out_pred(rsp.prediction_count)
   );
endmodule
